FILE: rtl/core/frame_count_to_smpte_timecode_core_macros.svh
// Assertion macros shared by the timecode converter RTL.
`ifndef FRAME_COUNT_TO_SMPTE_TIMECODE_CORE_MACROS_SVH
`define FRAME_COUNT_TO_SMPTE_TIMECODE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FC2TC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timecode converter assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FC2TC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timecode converter assertion failed");

`endif

FILE: rtl/core/fc2tc_pkg.sv
// Package with types and constants of the frame count to timecode converter.
`default_nettype none

package fc2tc_pkg;

    // Field and register widths.
    localparam int RATE_W   = 7;
    localparam int INDEX_W  = 31;
    localparam int HOURS_W  = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int FRAMES_W = 7;
    localparam int DROP_W   = 3;
    localparam int PMIN_W   = 13;
    localparam int PTEN_W   = 17;
    localparam int PHOUR_W  = 19;
    localparam int CNT_W    = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register map.
    localparam logic [PADDR_W-1:0] ADDR_FRAME_RATE = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_DROP_MODE  = 3'd4;

    // Reset values of the registers.
    localparam logic [RATE_W-1:0] FRAME_RATE_RST = 7'd30;
    localparam logic              DROP_MODE_RST  = 1'b0;

    // Timecode constants.
    localparam int SEC_PER_MIN     = 60;
    localparam int MIN_PER_BLOCK   = 10;
    localparam int DROP_MINUTES    = 9;
    localparam int BLOCKS_PER_HOUR = 6;
    localparam int HOURS_PER_DAY   = 24;
    localparam int LAST_SECONDS    = 59;
    localparam int FAST_RATE       = 60;
    localparam logic [DROP_W-1:0] DROP_FAST = 3'd4;
    localparam logic [DROP_W-1:0] DROP_STD  = 3'd2;

    // Bit indexes of the first bit fed to the divider in each stage.
    localparam logic [CNT_W-1:0] CNT_HOUR = 5'd30;
    localparam logic [CNT_W-1:0] CNT_TEN  = 5'd18;
    localparam logic [CNT_W-1:0] CNT_MIN  = 5'd16;
    localparam logic [CNT_W-1:0] CNT_SEC  = 5'd12;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_POST
    } t_state;

    // Which division the shared divider is working on.
    typedef enum logic [1:0] {
        ST_HOUR,
        ST_TEN,
        ST_MIN,
        ST_SEC
    } t_stage;

endpackage

`default_nettype wire

FILE: rtl/core/frame_count_to_smpte_timecode_core.sv
// Top level of the frame count to SMPTE timecode converter.
//
//  channel   direction  handshake                        payload
//  command   in         start & !busy                    i_frame_index
//  result    out        o_done (one cycle, no backpress) o_hours .. o_overflow
//  config    in         psel & penable & pwrite & pready pwdata, paddr, prdata
//
// One shared restoring divider, one quotient bit per cycle, does every division.
// A conversion divides for the hour, for the ten-minute block and for the minute or
// second, once more for the second past second zero of a dropped minute, with a fix-up
// step after each division; a count of 24 hours or more ends after the hour division.
// busy is high from the cycle after acceptance until the result strobe.
// Reset is synchronous, active low, and restores the register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

`include "frame_count_to_smpte_timecode_core_macros.svh"

module frame_count_to_smpte_timecode_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Command channel.
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [fc2tc_pkg::INDEX_W-1:0]      i_frame_index,
    // Result channel.
    output logic                                    o_done,
    output logic [fc2tc_pkg::HOURS_W-1:0]           o_hours,
    output logic [fc2tc_pkg::MIN_W-1:0]             o_minutes,
    output logic [fc2tc_pkg::SEC_W-1:0]             o_seconds,
    output logic [fc2tc_pkg::FRAMES_W-1:0]          o_frames,
    output logic                                    o_is_drop,
    output logic                                    o_overflow,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fc2tc_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [fc2tc_pkg::PDATA_W-1:0]      pwdata,
    output logic [fc2tc_pkg::PDATA_W-1:0]           prdata,
    output logic                                    pready
);

    // Sequencer and divider registers.
    fc2tc_pkg::t_state                     r_state, n_state;
    fc2tc_pkg::t_stage                     r_stage, n_stage;
    logic                                  r_done, n_done;
    logic [fc2tc_pkg::INDEX_W-1:0]         r_dvd, n_dvd;
    logic [fc2tc_pkg::PHOUR_W-1:0]         r_div, n_div;
    logic [fc2tc_pkg::PHOUR_W-1:0]         r_rem, n_rem;
    logic [fc2tc_pkg::INDEX_W-1:0]         r_quo, n_quo;
    logic [fc2tc_pkg::CNT_W-1:0]           r_cnt, n_cnt;
    logic                                  r_sec_base, n_sec_base;

    // Configuration registers.
    logic [fc2tc_pkg::RATE_W-1:0]          r_frame_rate;
    logic                                  r_drop_mode;

    // Per-transaction constants derived from the configuration.
    logic [fc2tc_pkg::RATE_W-1:0]          r_rate, n_rate;
    logic [fc2tc_pkg::DROP_W-1:0]          r_drop, n_drop;
    logic [fc2tc_pkg::PMIN_W-1:0]          r_per_min, n_per_min;
    logic [fc2tc_pkg::RATE_W-1:0]          r_first, n_first;
    logic [fc2tc_pkg::PMIN_W-1:0]          r_mlen, n_mlen;
    logic [fc2tc_pkg::PTEN_W-1:0]          r_per_ten, n_per_ten;

    // Result registers.
    logic [fc2tc_pkg::HOURS_W-1:0]         r_hours, n_hours;
    logic [fc2tc_pkg::MIN_W-1:0]           r_minutes, n_minutes;
    logic [fc2tc_pkg::SEC_W-1:0]           r_seconds, n_seconds;
    logic [fc2tc_pkg::FRAMES_W-1:0]        r_frames, n_frames;
    logic                                  r_is_drop, n_is_drop;
    logic                                  r_overflow, n_overflow;

    // Combinational helpers.
    logic                                  cfg_write;
    logic                                  accept;
    logic [fc2tc_pkg::RATE_W-1:0]          rate_eff;
    logic [fc2tc_pkg::DROP_W-1:0]          drop_eff;
    logic [fc2tc_pkg::PMIN_W-1:0]          per_min_eff;
    logic [fc2tc_pkg::PTEN_W-1:0]          per_ten_eff;
    logic [fc2tc_pkg::PHOUR_W-1:0]         per_hour_eff;
    logic [fc2tc_pkg::RATE_W-1:0]          first_eff;
    logic [fc2tc_pkg::PMIN_W-1:0]          mlen_eff;
    logic [fc2tc_pkg::PHOUR_W:0]           trial;
    logic [fc2tc_pkg::PHOUR_W:0]           trial_diff;
    logic                                  trial_ge;
    logic [fc2tc_pkg::PMIN_W-1:0]          min_rem;

    assign cfg_write = psel && penable && pwrite && pready;
    assign accept    = start && !busy;
    assign busy      = (r_state != fc2tc_pkg::S_IDLE);
    assign pready    = 1'b1;

    // Register read-back.
    always_comb begin
        case (paddr)
            fc2tc_pkg::ADDR_FRAME_RATE:
                prdata = {{(fc2tc_pkg::PDATA_W-fc2tc_pkg::RATE_W){1'b0}}, r_frame_rate};
            fc2tc_pkg::ADDR_DROP_MODE:
                prdata = {{(fc2tc_pkg::PDATA_W-1){1'b0}}, r_drop_mode};
            default:
                prdata = '0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rate <= fc2tc_pkg::FRAME_RATE_RST;
            r_drop_mode  <= fc2tc_pkg::DROP_MODE_RST;
        end else if (cfg_write) begin
            case (paddr)
                fc2tc_pkg::ADDR_FRAME_RATE: r_frame_rate <= pwdata[fc2tc_pkg::RATE_W-1:0];
                fc2tc_pkg::ADDR_DROP_MODE:  r_drop_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Block sizes for the configured rate and mode; a zero rate counts as one.
    always_comb begin
        rate_eff     = (r_frame_rate == '0) ? 7'd1 : r_frame_rate;
        drop_eff     = !r_drop_mode ? 3'd0 :
                       ((rate_eff == 7'(fc2tc_pkg::FAST_RATE)) ? fc2tc_pkg::DROP_FAST
                                                               : fc2tc_pkg::DROP_STD);
        per_min_eff  = 13'(32'(rate_eff) * fc2tc_pkg::SEC_PER_MIN);
        per_ten_eff  = 17'(32'(rate_eff) * (fc2tc_pkg::SEC_PER_MIN * fc2tc_pkg::MIN_PER_BLOCK)
                       - 32'(drop_eff) * fc2tc_pkg::DROP_MINUTES);
        per_hour_eff = 19'(32'(per_ten_eff) * fc2tc_pkg::BLOCKS_PER_HOUR);
        first_eff    = ({4'd0, drop_eff} < rate_eff) ? (rate_eff - {4'd0, drop_eff}) : 7'd1;
        mlen_eff     = 13'(32'(first_eff) + 32'(rate_eff) * fc2tc_pkg::LAST_SECONDS);
    end

    // Shared divider step: shift in one dividend bit, compare and subtract.
    always_comb begin
        trial      = {r_rem, r_dvd[r_cnt]};
        trial_diff = trial - {1'b0, r_div};
        trial_ge   = (trial >= {1'b0, r_div});
        min_rem    = r_rem[fc2tc_pkg::PMIN_W-1:0];
    end

    // Sequencer: next state, divider loads and result capture.
    always_comb begin
        n_state    = r_state;
        n_stage    = r_stage;
        n_done     = 1'b0;
        n_dvd      = r_dvd;
        n_div      = r_div;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_sec_base = r_sec_base;
        n_rate     = r_rate;
        n_drop     = r_drop;
        n_per_min  = r_per_min;
        n_first    = r_first;
        n_mlen     = r_mlen;
        n_per_ten  = r_per_ten;
        n_hours    = r_hours;
        n_minutes  = r_minutes;
        n_seconds  = r_seconds;
        n_frames   = r_frames;
        n_is_drop  = r_is_drop;
        n_overflow = r_overflow;

        case (r_state)
            fc2tc_pkg::S_IDLE: begin
                if (accept) begin
                    n_rate    = rate_eff;
                    n_drop    = drop_eff;
                    n_per_min = per_min_eff;
                    n_first   = first_eff;
                    n_mlen    = mlen_eff;
                    n_per_ten = per_ten_eff;
                    n_dvd     = i_frame_index;
                    n_div     = per_hour_eff;
                    n_rem     = '0;
                    n_quo     = '0;
                    n_cnt     = fc2tc_pkg::CNT_HOUR;
                    n_stage   = fc2tc_pkg::ST_HOUR;
                    n_state   = fc2tc_pkg::S_DIV;
                end
            end

            fc2tc_pkg::S_DIV: begin
                n_rem = trial_ge ? trial_diff[fc2tc_pkg::PHOUR_W-1:0]
                                 : trial[fc2tc_pkg::PHOUR_W-1:0];
                n_quo = {r_quo[fc2tc_pkg::INDEX_W-2:0], trial_ge};
                if (r_cnt == '0) begin
                    n_state = fc2tc_pkg::S_POST;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end

            fc2tc_pkg::S_POST: begin
                n_rem   = '0;
                n_quo   = '0;
                n_state = fc2tc_pkg::S_DIV;
                case (r_stage)
                    fc2tc_pkg::ST_HOUR: begin
                        if (r_quo >= 31'(fc2tc_pkg::HOURS_PER_DAY)) begin
                            // Day overflow: report zeros with the flag.
                            n_hours    = '0;
                            n_minutes  = '0;
                            n_seconds  = '0;
                            n_frames   = '0;
                            n_overflow = 1'b1;
                            n_is_drop  = r_drop_mode;
                            n_done     = 1'b1;
                            n_state    = fc2tc_pkg::S_IDLE;
                        end else begin
                            n_hours = r_quo[fc2tc_pkg::HOURS_W-1:0];
                            n_dvd   = {12'd0, r_rem};
                            n_div   = {2'd0, r_per_ten};
                            n_cnt   = fc2tc_pkg::CNT_TEN;
                            n_stage = fc2tc_pkg::ST_TEN;
                        end
                    end

                    fc2tc_pkg::ST_TEN: begin
                        n_minutes = 6'(32'(r_quo[2:0]) * fc2tc_pkg::MIN_PER_BLOCK);
                        n_cnt     = fc2tc_pkg::CNT_MIN;
                        if (r_rem < {6'd0, r_per_min}) begin
                            // First minute of a block is never dropped.
                            n_dvd      = {12'd0, r_rem};
                            n_div      = {12'd0, r_rate};
                            n_sec_base = 1'b0;
                            n_stage    = fc2tc_pkg::ST_SEC;
                        end else begin
                            n_dvd   = {12'd0, r_rem - {6'd0, r_per_min}};
                            n_div   = {6'd0, r_mlen};
                            n_stage = fc2tc_pkg::ST_MIN;
                        end
                    end

                    fc2tc_pkg::ST_MIN: begin
                        n_minutes = r_minutes + 6'd1 + {2'd0, r_quo[3:0]};
                        if (min_rem < {6'd0, r_first}) begin
                            // Inside second zero of a dropped minute.
                            n_seconds  = '0;
                            n_frames   = 7'({4'd0, r_drop} + min_rem);
                            n_overflow = 1'b0;
                            n_is_drop  = r_drop_mode;
                            n_done     = 1'b1;
                            n_state    = fc2tc_pkg::S_IDLE;
                        end else begin
                            n_dvd      = {18'd0, min_rem - {6'd0, r_first}};
                            n_div      = {12'd0, r_rate};
                            n_cnt      = fc2tc_pkg::CNT_SEC;
                            n_sec_base = 1'b1;
                            n_stage    = fc2tc_pkg::ST_SEC;
                        end
                    end

                    fc2tc_pkg::ST_SEC: begin
                        n_seconds  = r_quo[fc2tc_pkg::SEC_W-1:0] + {5'd0, r_sec_base};
                        n_frames   = r_rem[fc2tc_pkg::FRAMES_W-1:0];
                        n_overflow = 1'b0;
                        n_is_drop  = r_drop_mode;
                        n_done     = 1'b1;
                        n_state    = fc2tc_pkg::S_IDLE;
                    end

                    default: begin
                        n_state = fc2tc_pkg::S_IDLE;
                    end
                endcase
            end

            default: begin
                n_state = fc2tc_pkg::S_IDLE;
            end
        endcase
    end

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fc2tc_pkg::S_IDLE;
            r_stage <= fc2tc_pkg::ST_HOUR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_done  <= n_done;
        end
        r_dvd      <= n_dvd;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_sec_base <= n_sec_base;
        r_rate     <= n_rate;
        r_drop     <= n_drop;
        r_per_min  <= n_per_min;
        r_first    <= n_first;
        r_mlen     <= n_mlen;
        r_per_ten  <= n_per_ten;
        r_hours    <= n_hours;
        r_minutes  <= n_minutes;
        r_seconds  <= n_seconds;
        r_frames   <= n_frames;
        r_is_drop  <= n_is_drop;
        r_overflow <= n_overflow;
    end

    assign o_done     = r_done;
    assign o_hours    = r_hours;
    assign o_minutes  = r_minutes;
    assign o_seconds  = r_seconds;
    assign o_frames   = r_frames;
    assign o_is_drop  = r_is_drop;
    assign o_overflow = r_overflow;

    // The result strobe comes only while the sequencer is back in idle.
    `FC2TC_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // An accepted transaction keeps the block busy in the next cycle.
    `FC2TC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    // A valid timecode stays inside its field ranges.
    `FC2TC_ASSERT_NOW(a_tc_range, i_clk, i_rst_n, o_done && !o_overflow,
        (o_hours < 5'd24) && (o_minutes < 6'd60) && (o_seconds < 6'd60))
    // An overflow result carries zero timecode fields.
    `FC2TC_ASSERT_NOW(a_ovf_zero, i_clk, i_rst_n, o_done && o_overflow,
        (o_hours == '0) && (o_minutes == '0) && (o_seconds == '0) && (o_frames == '0))

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the frame count to SMPTE timecode converter.
module tb_top;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 40;

    // One converted timecode as it leaves the block.
    typedef struct packed {
        logic [fc2tc_pkg::HOURS_W-1:0]  hours;
        logic [fc2tc_pkg::MIN_W-1:0]    minutes;
        logic [fc2tc_pkg::SEC_W-1:0]    seconds;
        logic [fc2tc_pkg::FRAMES_W-1:0] frames;
        logic                           is_drop;
        logic                           overflow;
    } t_timecode;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic [fc2tc_pkg::INDEX_W-1:0]     i_frame_index = '0;
    logic                              o_done;
    logic [fc2tc_pkg::HOURS_W-1:0]     o_hours;
    logic [fc2tc_pkg::MIN_W-1:0]       o_minutes;
    logic [fc2tc_pkg::SEC_W-1:0]       o_seconds;
    logic [fc2tc_pkg::FRAMES_W-1:0]    o_frames;
    logic                              o_is_drop;
    logic                              o_overflow;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [fc2tc_pkg::PADDR_W-1:0]     paddr = '0;
    logic [fc2tc_pkg::PDATA_W-1:0]     pwdata = '0;
    logic [fc2tc_pkg::PDATA_W-1:0]     prdata;
    logic                              pready;

    // Shadow copy of the configuration registers.
    logic [fc2tc_pkg::RATE_W-1:0]      cfg_rate = fc2tc_pkg::FRAME_RATE_RST;
    logic                              cfg_drop = fc2tc_pkg::DROP_MODE_RST;

    t_timecode                         pending_timecodes[$];
    int unsigned                       mismatch_count = 0;
    int unsigned                       cycle_count = 0;
    logic                              no_idle = 1'b0;

    frame_count_to_smpte_timecode_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_frame_index (i_frame_index),
        .o_done        (o_done),
        .o_hours       (o_hours),
        .o_minutes     (o_minutes),
        .o_seconds     (o_seconds),
        .o_frames      (o_frames),
        .o_is_drop     (o_is_drop),
        .o_overflow    (o_overflow),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Free-running clock.
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Counts a failure and prints the first few of them.
    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    // Sizes of the timecode units under the current configuration.
    function automatic void timecode_geometry(output longint unsigned rate,
                                              output longint unsigned drop,
                                              output longint unsigned per_min,
                                              output longint unsigned per_ten,
                                              output longint unsigned first,
                                              output longint unsigned mlen);
        rate = (cfg_rate == 0) ? 1 : cfg_rate;
        if (!cfg_drop) begin
            drop = 0;
        end else begin
            drop = (rate == fc2tc_pkg::FAST_RATE) ? fc2tc_pkg::DROP_FAST
                                                  : fc2tc_pkg::DROP_STD;
        end
        per_min = rate * fc2tc_pkg::SEC_PER_MIN;
        per_ten = per_min * fc2tc_pkg::MIN_PER_BLOCK - fc2tc_pkg::DROP_MINUTES * drop;
        // A dropped minute keeps at least one frame in its first second.
        first = (drop < rate) ? rate - drop : 1;
        mlen = first + fc2tc_pkg::LAST_SECONDS * rate;
    endfunction

    // Number of frames in 24 hours of timecode.
    function automatic longint unsigned day_frames();
        longint unsigned rate, drop, per_min, per_ten, first, mlen;
        timecode_geometry(rate, drop, per_min, per_ten, first, mlen);
        return fc2tc_pkg::HOURS_PER_DAY * fc2tc_pkg::BLOCKS_PER_HOUR * per_ten;
    endfunction

    // Expected timecode of one frame count under the shadow configuration.
    function automatic t_timecode predict_timecode(
        input logic [fc2tc_pkg::INDEX_W-1:0] idx);
        longint unsigned rate, drop, per_min, per_ten, first, mlen;
        longint unsigned per_hour, n, h, r, m, s, f, k, q;
        t_timecode tc;
        timecode_geometry(rate, drop, per_min, per_ten, first, mlen);
        per_hour = fc2tc_pkg::BLOCKS_PER_HOUR * per_ten;
        n = idx;
        h = n / per_hour;
        tc = '0;
        tc.is_drop = cfg_drop;
        if (h >= fc2tc_pkg::HOURS_PER_DAY) begin
            tc.overflow = 1'b1;
            return tc;
        end
        r = n % per_hour;
        m = (r / per_ten) * fc2tc_pkg::MIN_PER_BLOCK;
        r = r % per_ten;
        if (r < per_min) begin
            // The first minute of each ten-minute block is never dropped.
            s = r / rate;
            f = r % rate;
        end else begin
            r = r - per_min;
            k = r / mlen;
            q = r % mlen;
            m = m + 1 + k;
            if (q < first) begin
                s = 0;
                f = drop + q;
            end else begin
                q = q - first;
                s = 1 + q / rate;
                f = q % rate;
            end
        end
        tc.hours   = fc2tc_pkg::HOURS_W'(h);
        tc.minutes = fc2tc_pkg::MIN_W'(m);
        tc.seconds = fc2tc_pkg::SEC_W'(s);
        tc.frames  = fc2tc_pkg::FRAMES_W'(f);
        return tc;
    endfunction

    // Result checker: every strobe is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_timecode got;
        t_timecode want;
        if (i_rst_n && o_done) begin
            got = '{o_hours, o_minutes, o_seconds, o_frames, o_is_drop, o_overflow};
            if (pending_timecodes.size() == 0) begin
                note_mismatch($sformatf("unexpected result %0d:%0d:%0d:%0d drop %0b ovf %0b",
                    got.hours, got.minutes, got.seconds, got.frames,
                    got.is_drop, got.overflow));
            end else begin
                want = pending_timecodes.pop_front();
                if (got.hours !== want.hours || got.minutes !== want.minutes ||
                    got.seconds !== want.seconds || got.frames !== want.frames ||
                    got.is_drop !== want.is_drop || got.overflow !== want.overflow) begin
                    note_mismatch($sformatf({"expected %0d:%0d:%0d:%0d drop %0b ovf %0b, ",
                                             "got %0d:%0d:%0d:%0d drop %0b ovf %0b"},
                        want.hours, want.minutes, want.seconds, want.frames,
                        want.is_drop, want.overflow,
                        got.hours, got.minutes, got.seconds, got.frames,
                        got.is_drop, got.overflow));
                end
            end
        end
    end

    // Sends one frame count; called and returning at a falling edge.
    task automatic send_frame(input logic [fc2tc_pkg::INDEX_W-1:0] idx);
        logic        wait_free;
        int unsigned gap;
        wait_free = !no_idle && ($urandom_range(0, 1) == 1);
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        // Drop start first so that a held item is not taken twice.
        if (wait_free || gap != 0) begin
            start <= 1'b0;
            if (wait_free) begin
                do @(negedge i_clk); while (busy);
            end
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_frame_index <= idx;
        do @(posedge i_clk); while (busy);
        pending_timecodes.push_back(predict_timecode(idx));
        @(negedge i_clk);
    endtask

    // Waits until every expected result has come and the block is free.
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_timecodes.size() != 0 || busy);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write transaction with setup and access cycles.
    task automatic write_register(input logic [fc2tc_pkg::PADDR_W-1:0] addr,
                                  input logic [fc2tc_pkg::PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == fc2tc_pkg::ADDR_FRAME_RATE) begin
            cfg_rate = data[fc2tc_pkg::RATE_W-1:0];
        end else if (addr == fc2tc_pkg::ADDR_DROP_MODE) begin
            cfg_drop = data[0];
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // Register read transaction, compared with the shadow value.
    task automatic check_register(input logic [fc2tc_pkg::PADDR_W-1:0] addr,
                                  input logic [fc2tc_pkg::PDATA_W-1:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            note_mismatch($sformatf("register at %0d reads %0h, expected %0h",
                addr, prdata, want));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Sets a new rate and mode once the block is idle, with random upper bits.
    task automatic configure(input logic [fc2tc_pkg::RATE_W-1:0] rate, input logic drop);
        drain_results();
        write_register(fc2tc_pkg::ADDR_FRAME_RATE, ($urandom() & 32'hFFFF_FF80) | rate);
        write_register(fc2tc_pkg::ADDR_DROP_MODE, ($urandom() & 32'hFFFF_FFFE) | drop);
        check_register(fc2tc_pkg::ADDR_FRAME_RATE,
            {{(fc2tc_pkg::PDATA_W-fc2tc_pkg::RATE_W){1'b0}}, cfg_rate});
        check_register(fc2tc_pkg::ADDR_DROP_MODE, {{(fc2tc_pkg::PDATA_W-1){1'b0}}, cfg_drop});
    endtask

    // Reset values, then minute, hour and day boundaries at 30 fps non-drop.
    task automatic test_reset_defaults();
        check_register(fc2tc_pkg::ADDR_FRAME_RATE,
            {{(fc2tc_pkg::PDATA_W-fc2tc_pkg::RATE_W){1'b0}}, fc2tc_pkg::FRAME_RATE_RST});
        check_register(fc2tc_pkg::ADDR_DROP_MODE,
            {{(fc2tc_pkg::PDATA_W-1){1'b0}}, fc2tc_pkg::DROP_MODE_RST});
        send_frame('0);
        send_frame(fc2tc_pkg::INDEX_W'(1799));
        send_frame(fc2tc_pkg::INDEX_W'(1800));
        send_frame(fc2tc_pkg::INDEX_W'(107999));
        send_frame(fc2tc_pkg::INDEX_W'(day_frames() - 1));
    endtask

    // Counts at and beyond 24 hours, including the all-ones count.
    task automatic test_index_extremes();
        send_frame(fc2tc_pkg::INDEX_W'(day_frames()));
        send_frame({fc2tc_pkg::INDEX_W{1'b1}});
        send_frame(fc2tc_pkg::INDEX_W'(31'h5555_5555));
        send_frame(fc2tc_pkg::INDEX_W'(31'h2AAA_AAAA));
    endtask

    // Minute and ten-minute boundaries in drop-frame mode.
    task automatic test_drop_minutes();
        configure(7'd30, 1'b1);
        send_frame(fc2tc_pkg::INDEX_W'(1799));
        send_frame(fc2tc_pkg::INDEX_W'(1800));
        send_frame(fc2tc_pkg::INDEX_W'(17981));
        send_frame(fc2tc_pkg::INDEX_W'(17982));
        send_frame(fc2tc_pkg::INDEX_W'(17982 + 1800));
        configure(7'd60, 1'b1);
        send_frame(fc2tc_pkg::INDEX_W'(3599));
        send_frame(fc2tc_pkg::INDEX_W'(3600));
        send_frame(fc2tc_pkg::INDEX_W'(35964));
    endtask

    // Zero rate and rates not above the drop count.
    task automatic test_tiny_rates();
        configure(7'd0, 1'b0);
        send_frame(fc2tc_pkg::INDEX_W'(59));
        send_frame(fc2tc_pkg::INDEX_W'(60));
        configure(7'd1, 1'b1);
        send_frame(fc2tc_pkg::INDEX_W'(60));
        send_frame(fc2tc_pkg::INDEX_W'(61));
        configure(7'd2, 1'b1);
        send_frame(fc2tc_pkg::INDEX_W'(120));
        send_frame(fc2tc_pkg::INDEX_W'(121));
    endtask

    // Highest rates, including values beyond the nominal range.
    task automatic test_fast_rates();
        configure(7'd127, 1'b0);
        send_frame(fc2tc_pkg::INDEX_W'(day_frames() - 1));
        send_frame(fc2tc_pkg::INDEX_W'(day_frames()));
        configure(7'd120, 1'b1);
        send_frame(fc2tc_pkg::INDEX_W'(7199));
        send_frame(fc2tc_pkg::INDEX_W'(7200));
    endtask

    // Random counts under a series of settings, biased toward unit boundaries.
    task automatic test_random_counts();
        logic [fc2tc_pkg::RATE_W-1:0] rate_list[9];
        longint unsigned              rate, drop, per_min, per_ten, first, mlen, day, base;
        int unsigned                  pick;
        rate_list = '{7'd1, 7'd2, 7'd24, 7'd25, 7'd30, 7'd60, 7'd120, 7'd127, 7'd0};
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure((phase < 9) ? rate_list[phase]
                                  : fc2tc_pkg::RATE_W'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
            no_idle = (phase % 4 == 1);
            timecode_geometry(rate, drop, per_min, per_ten, first, mlen);
            day = day_frames();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    send_frame(fc2tc_pkg::INDEX_W'($urandom()));
                end else if (pick == 1) begin
                    send_frame(fc2tc_pkg::INDEX_W'(day - 4 + $urandom_range(0, 7)));
                end else if (pick <= 4) begin
                    // Near the start of a random minute, dropped or not.
                    int unsigned minute;
                    minute = $urandom_range(0, 9);
                    base = $urandom_range(0, 23) * fc2tc_pkg::BLOCKS_PER_HOUR * per_ten
                         + $urandom_range(0, 5) * per_ten;
                    if (minute != 0) begin
                        base = base + per_min + (minute - 1) * mlen;
                    end
                    if (base > 0 && $urandom_range(0, 1) == 1) begin
                        base = base - 1;
                    end
                    send_frame(fc2tc_pkg::INDEX_W'(base + $urandom_range(0, 3)));
                end else begin
                    send_frame(fc2tc_pkg::INDEX_W'($urandom_range(0, 32'(day - 1))));
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_index_extremes();
        test_drop_minutes();
        test_tiny_rates();
        test_fast_rates();
        test_random_counts();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
